// ===== rtl/core/ssfe_pkg.sv =====
// Package for the seven-segment frame encoder: shared types, bus byte codes,
// command codes, the per-stage work word and the digit glyph lookup.
// No dependencies.
package ssfe_pkg;

    typedef logic [1:0]  cmd_t;
    typedef logic [3:0]  digit_t;
    typedef logic [13:0] num_t;
    typedef logic [6:0]  tval_t;
    typedef logic [7:0]  octet_t;
    typedef octet_t [3:0] seg_t;
    typedef logic [2:0]  slot_t;
    typedef logic [2:0]  bright_t;

    localparam cmd_t CMD_NUMBER = 2'd0;
    localparam cmd_t CMD_TIME   = 2'd1;
    localparam cmd_t CMD_DASHES = 2'd2;

    localparam num_t    NUM_CAP      = 14'd9999;
    localparam bright_t BRIGHT_RESET = 3'd7;

    localparam octet_t BYTE_DATA_CMD  = 8'h40;
    localparam octet_t BYTE_ADDR_CMD  = 8'hC0;
    localparam octet_t BYTE_DISP_CTRL = 8'h88;
    localparam octet_t SEG_DASH       = 8'h40;
    localparam octet_t SEG_COLON      = 8'h80;
    localparam octet_t SEG_BLANK      = 8'h00;

    // Divide by ten as a multiply by 2^19/10, rounded up; exact for values up to 9999.
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    // Position of a word within the seven-word sequence of one command.
    localparam slot_t SLOT_DATA_CMD = 3'd0;
    localparam slot_t SLOT_ADDR_CMD = 3'd1;
    localparam slot_t SLOT_SEG0     = 3'd2;
    localparam slot_t SLOT_SEG1     = 3'd3;
    localparam slot_t SLOT_SEG2     = 3'd4;
    localparam slot_t SLOT_SEG3     = 3'd5;
    localparam slot_t SLOT_CTRL     = 3'd6;

    // Work word carried down the digit pipeline. Number digits nd[0] is the
    // thousands digit; time digits td[0..3] are hours tens, hours units,
    // minutes tens, minutes units.
    typedef struct packed {
        cmd_t           cmd;
        num_t           num;
        tval_t          hrs;
        tval_t          mins;
        logic           colon;
        digit_t [3:0]   nd;
        digit_t [3:0]   td;
    } work_t;

    function automatic octet_t glyph(input digit_t d);
        octet_t g;
        unique case (d)
            4'd0:    g = 8'h3F;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5B;
            4'd3:    g = 8'h4F;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6D;
            4'd6:    g = 8'h7D;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7F;
            4'd9:    g = 8'h6F;
            default: g = SEG_BLANK;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/core/ssfe_if.sv =====
// Channel interfaces of the seven-segment frame encoder: command input,
// bus word output and brightness write channel.
// Depends on ssfe_pkg.
interface ssfe_in_if import ssfe_pkg::*; ();
    logic        valid;
    logic        ready;
    cmd_t        cmd;
    logic [31:0] value;
    tval_t       hours;
    tval_t       minutes;
    logic        colon_on;

    modport source (output valid, cmd, value, hours, minutes, colon_on, input ready);
    modport sink   (input valid, cmd, value, hours, minutes, colon_on, output ready);
endinterface

interface ssfe_out_if import ssfe_pkg::*; ();
    logic   valid;
    logic   ready;
    octet_t bus_byte;
    logic   frame_start;
    logic   frame_end;
    logic   run_last;

    modport source (output valid, bus_byte, frame_start, frame_end, run_last, input ready);
    modport sink   (input valid, bus_byte, frame_start, frame_end, run_last, output ready);
endinterface

interface ssfe_cfg_if import ssfe_pkg::*; ();
    logic    valid;
    logic    ready;
    bright_t brightness;

    modport source (output valid, brightness, input ready);
    modport sink   (input valid, brightness, output ready);
endinterface

// ===== rtl/core/ssfe_peel.sv =====
// Splits the lowest decimal digit off a value of at most 9999.
// Depends on ssfe_pkg.
module ssfe_peel import ssfe_pkg::*;
(
    input  num_t       x,
    output logic [9:0] q,
    output digit_t     r
);

    logic [29:0] prod;
    num_t        tens;
    num_t        diff;

    assign prod = {16'd0, x} * {14'd0, DIV10_MUL};
    assign q    = prod[DIV10_SHIFT +: 10];
    // q * 10 as two shifted copies.
    assign tens = {1'b0, q, 3'b000} + {3'b000, q, 1'b0};
    assign diff = x - tens;
    assign r    = diff[3:0];

endmodule

// ===== rtl/core/ssfe_digit_stage.sv =====
// One registered stage of the digit pipeline: peels one decimal digit off the
// number and, in the first two stages, one off the hours and the minutes.
// Depends on ssfe_pkg and ssfe_peel.
module ssfe_digit_stage import ssfe_pkg::*;
#(
    parameter int STAGE = 1
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    output logic  up_ready,
    input  work_t up_work,
    output logic  down_valid,
    input  logic  down_ready,
    output work_t down_work
);

    work_t       work_reg;
    work_t       work_next;
    logic        vld_reg;
    logic [9:0]  num_q;
    digit_t      num_r;
    logic [9:0]  hrs_q;
    digit_t      hrs_r;
    logic [9:0]  mins_q;
    digit_t      mins_r;

    ssfe_peel u_num_peel
    (
        .x (up_work.num),
        .q (num_q),
        .r (num_r)
    );

    ssfe_peel u_hrs_peel
    (
        .x ({7'd0, up_work.hrs}),
        .q (hrs_q),
        .r (hrs_r)
    );

    ssfe_peel u_mins_peel
    (
        .x ({7'd0, up_work.mins}),
        .q (mins_q),
        .r (mins_r)
    );

    always_comb
    begin
        work_next = up_work;
        work_next.num = {4'd0, num_q};
        work_next.nd[2'(4 - STAGE)] = num_r;
        if (STAGE == 1)
        begin
            work_next.td[1] = hrs_r;
            work_next.td[3] = mins_r;
            work_next.hrs   = hrs_q[6:0];
            work_next.mins  = mins_q[6:0];
        end
        else if (STAGE == 2)
        begin
            // Hours above 99 keep only the tens digit modulo ten.
            work_next.td[0] = hrs_r;
            work_next.td[2] = mins_r;
        end
        else
        begin
            // What is left after three digits is the thousands digit.
            work_next.nd[0] = num_q[3:0];
        end
    end

    assign up_ready   = !vld_reg || down_ready;
    assign down_valid = vld_reg;
    assign down_work  = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            work_reg <= work_next;
        end
    end

endmodule

// ===== rtl/core/ssfe_encoder.sv =====
// Command input register, three digit stages and the glyph and blanking
// logic that turns a command into four segment bytes.
// Depends on ssfe_pkg, ssfe_if and ssfe_digit_stage.
module ssfe_encoder import ssfe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    ssfe_in_if.sink req,
    output logic  seg_valid,
    input  logic  seg_ready,
    output seg_t  seg
);

    work_t      in_reg;
    work_t      in_next;
    logic       in_vld_reg;
    logic [3:0] vld;
    logic [3:0] take;
    work_t      work [4];
    work_t      w;
    logic       blank0;
    logic       blank1;
    logic       blank2;

    always_comb
    begin
        in_next       = '0;
        in_next.cmd   = req.cmd;
        in_next.num   = (req.value > {18'd0, NUM_CAP}) ? NUM_CAP : req.value[13:0];
        in_next.hrs   = req.hours;
        in_next.mins  = req.minutes;
        in_next.colon = req.colon_on;
    end

    assign req.ready = !in_vld_reg || take[0];
    assign vld[0]    = in_vld_reg;
    assign work[0]   = in_reg;
    assign take[3]   = seg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_reg <= in_next;
        end
    end

    for (genvar k = 1; k < 4; k++)
    begin : g_stage
        ssfe_digit_stage #(.STAGE(k)) u_stage
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (vld[k-1]),
            .up_ready   (take[k-1]),
            .up_work    (work[k-1]),
            .down_valid (vld[k]),
            .down_ready (take[k]),
            .down_work  (work[k])
        );
    end

    assign w         = work[3];
    assign seg_valid = vld[3];

    // Leading zeros go dark; the units position is always drawn.
    assign blank0 = (w.nd[0] == 4'd0);
    assign blank1 = blank0 && (w.nd[1] == 4'd0);
    assign blank2 = blank1 && (w.nd[2] == 4'd0);

    always_comb
    begin
        unique case (w.cmd)
            CMD_NUMBER:
            begin
                seg[0] = blank0 ? SEG_BLANK : glyph(w.nd[0]);
                seg[1] = blank1 ? SEG_BLANK : glyph(w.nd[1]);
                seg[2] = blank2 ? SEG_BLANK : glyph(w.nd[2]);
                seg[3] = glyph(w.nd[3]);
            end
            CMD_TIME:
            begin
                seg[0] = glyph(w.td[0]);
                seg[1] = glyph(w.td[1]) | (w.colon ? SEG_COLON : SEG_BLANK);
                seg[2] = glyph(w.td[2]);
                seg[3] = glyph(w.td[3]);
            end
            default:
            begin
                // The dash command and the unused code both draw dashes.
                seg[0] = SEG_DASH;
                seg[1] = SEG_DASH;
                seg[2] = SEG_DASH;
                seg[3] = SEG_DASH;
            end
        endcase
    end

endmodule

// ===== rtl/core/ssfe_serializer.sv =====
// Frame register, word sequencer, brightness register and output register
// that send the seven bus words of one command.
// Depends on ssfe_pkg and ssfe_if.
module ssfe_serializer import ssfe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  seg_valid,
    output logic  seg_ready,
    input  seg_t  seg,
    ssfe_cfg_if.sink cfg,
    ssfe_out_if.source bus
);

    logic    frm_vld_reg;
    seg_t    seg_reg;
    slot_t   slot_reg;
    bright_t bright_reg;
    logic    out_vld_reg;
    octet_t  out_byte_reg;
    logic    out_start_reg;
    logic    out_end_reg;
    logic    out_last_reg;
    octet_t  byte_next;
    logic    start_next;
    logic    end_next;
    logic    last_next;
    logic    out_adv;
    logic    emit;
    logic    frame_done;
    logic    load;

    assign out_adv    = !out_vld_reg || bus.ready;
    assign emit       = frm_vld_reg && out_adv;
    assign frame_done = emit && (slot_reg == SLOT_CTRL);
    // A new frame loads in the same cycle the last word of the old one leaves.
    assign seg_ready  = !frm_vld_reg || frame_done;
    assign load       = seg_valid && seg_ready;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        byte_next  = SEG_BLANK;
        start_next = 1'b0;
        end_next   = 1'b0;
        last_next  = 1'b0;
        unique case (slot_reg)
            SLOT_DATA_CMD:
            begin
                byte_next  = BYTE_DATA_CMD;
                start_next = 1'b1;
                end_next   = 1'b1;
            end
            SLOT_ADDR_CMD:
            begin
                byte_next  = BYTE_ADDR_CMD;
                start_next = 1'b1;
            end
            SLOT_SEG0: byte_next = seg_reg[0];
            SLOT_SEG1: byte_next = seg_reg[1];
            SLOT_SEG2: byte_next = seg_reg[2];
            SLOT_SEG3:
            begin
                byte_next = seg_reg[3];
                end_next  = 1'b1;
            end
            SLOT_CTRL:
            begin
                byte_next  = BYTE_DISP_CTRL | {5'd0, bright_reg};
                start_next = 1'b1;
                end_next   = 1'b1;
                last_next  = 1'b1;
            end
            default:
            begin
                byte_next = SEG_BLANK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frm_vld_reg <= 1'b0;
            slot_reg    <= SLOT_DATA_CMD;
            out_vld_reg <= 1'b0;
            bright_reg  <= BRIGHT_RESET;
        end
        else
        begin
            if (load)
            begin
                frm_vld_reg <= 1'b1;
                slot_reg    <= SLOT_DATA_CMD;
            end
            else if (emit)
            begin
                frm_vld_reg <= !frame_done;
                slot_reg    <= slot_reg + 3'd1;
            end
            if (out_adv)
            begin
                out_vld_reg <= frm_vld_reg;
            end
            if (cfg.valid && cfg.ready)
            begin
                bright_reg <= cfg.brightness;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seg_reg <= seg;
        end
        if (emit)
        begin
            out_byte_reg  <= byte_next;
            out_start_reg <= start_next;
            out_end_reg   <= end_next;
            out_last_reg  <= last_next;
        end
    end

    assign bus.valid       = out_vld_reg;
    assign bus.bus_byte    = out_byte_reg;
    assign bus.frame_start = out_start_reg;
    assign bus.frame_end   = out_end_reg;
    assign bus.run_last    = out_last_reg;

endmodule

// ===== rtl/core/seven_segment_frame_encoder.sv =====
// Seven-segment frame encoder. Each accepted command (show a number capped at
// 9999 with leading zeros blanked, show hours and minutes with an optional
// colon, or show dashes) yields seven bus words: 0x40 as a frame of its own,
// 0xC0 and the four segment bytes as a second frame, and 0x88 ORed with the
// brightness as a third, marked run_last. The serializer sends one word per
// cycle while the bus is ready. A command passes the input register, the three
// digit stages, the frame register and the output register before its first
// word appears, and up to five commands can be held in the input register, the
// three digit stages and the frame register.
// Brightness resets to 7 and is written through the cfg channel, which is
// always ready; write it only while no command is in flight.
module seven_segment_frame_encoder import ssfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ssfe_in_if.sink    req,
    ssfe_cfg_if.sink   cfg,
    ssfe_out_if.source bus
);

    logic seg_valid;
    logic seg_ready;
    seg_t seg;

    ssfe_encoder u_encoder
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg)
    );

    ssfe_serializer u_serializer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg),
        .cfg       (cfg),
        .bus       (bus)
    );

    // The closing word of a command is always a framed transfer of its own.
    a_last_framed: assert property (@(posedge clk) disable iff (!rst_n)
        bus.valid && bus.run_last |-> bus.frame_start && bus.frame_end)
        else $error("run_last word without start and stop");

    // After the fourth segment byte the control word follows at once.
    a_ctrl_follows: assert property (@(posedge clk) disable iff (!rst_n)
        bus.valid && bus.ready && bus.frame_end && !bus.frame_start
        |=> bus.valid && bus.run_last)
        else $error("control word did not follow the segment frame");

    // The lone data command word is followed at once by the address word.
    a_addr_follows: assert property (@(posedge clk) disable iff (!rst_n)
        bus.valid && bus.ready && !bus.run_last && bus.frame_start && bus.frame_end
        |=> bus.valid && bus.frame_start && !bus.frame_end
            && bus.bus_byte == BYTE_ADDR_CMD)
        else $error("address word did not follow the data command word");

endmodule
